FILE: rtl/fsr_pkg.sv
// Shared constants and types for the stream find-and-replace block.
`default_nettype none

package fsr_pkg;

    localparam int BYTE_W          = 8;
    localparam int MAX_PATTERN     = 8;
    localparam int MAX_REPLACEMENT = 8;

    localparam int FILL_W = $clog2(MAX_PATTERN + 1);
    localparam int IDX_W  = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int RLEN_W = $clog2(MAX_REPLACEMENT + 1);
    localparam int RIDX_W = (MAX_REPLACEMENT > 1) ? $clog2(MAX_REPLACEMENT) : 1;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;
    localparam int LEN_REG_W  = 4;

    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_BYTES      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REPLACEMENT_BYTES  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_REPLACEMENT_LENGTH = 2'd3;

    // Control broadcast to every window cell.
    typedef struct packed {
        logic              shift;
        logic [BYTE_W-1:0] din;
    } fsr_cell_ctl_t;

endpackage

`default_nettype wire

FILE: rtl/fsr_cell.sv
// One window cell: holds a byte, compares it to its pattern byte, shifts toward cell zero.
`default_nettype none

module fsr_cell
    import fsr_pkg::*;
(
    input  wire logic              aclk,
    input  wire fsr_cell_ctl_t     ctl,
    input  wire logic              wr,
    input  wire logic [BYTE_W-1:0] pat_byte,
    input  wire logic [BYTE_W-1:0] nbr_byte,
    output logic      [BYTE_W-1:0] eff_byte,
    output logic                   eq
);

    logic [BYTE_W-1:0] data_reg;
    logic [BYTE_W-1:0] data_next;

    // Byte as seen this cycle, including a write landing here now.
    assign eff_byte = wr ? ctl.din : data_reg;
    assign eq       = (eff_byte == pat_byte);

    always_comb begin
        data_next = data_reg;
        if (ctl.shift) begin
            data_next = nbr_byte;
        end else if (wr) begin
            data_next = ctl.din;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

endmodule

`default_nettype wire

FILE: rtl/stream_find_replace.sv
// Top level: streaming case-sensitive find-and-replace over a row of window cells.
//
// Input channel s_*: one text byte per item in s_tdata, s_tlast marks the final byte.
// Result channel m_*: one output byte per item in m_tdata; m_tuser[0] is set when the
// byte is a real character (clear on the empty end marker), m_tuser[1] marks the last
// result caused by one input item, m_tlast marks the final result of the whole text.
// Configuration: cfg_wr_en/cfg_addr/cfg_wdata write the search word, its length, the
// replacement word and its length; write only while no item is in flight. Writing the
// search length empties the window.
// Results are registered. A result made in the accepting cycle (pass-through, oldest
// window byte, empty end marker) shows on m_* in the cycle after the accept; the bytes of
// a replacement burst or of a flush come from ST_REPL or ST_FLUSH, entered after the accept.
// While in ST_REPL or ST_FLUSH, or while the output register is blocked, no new input
// item is taken.
// Reset (aresetn low, synchronous): registers return to search length 1, zeroed words,
// replacement length 0, empty window, no result pending.
// Receiver stall: the pending result holds on m_*, and s_tready stays low until it is
// taken; nothing is dropped.
`default_nettype none

module stream_find_replace
    import fsr_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [7:0]            s_tdata,   // [7:0] text_byte
    input  wire logic                  s_tlast,   // final_byte
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic      [7:0]            m_tdata,   // [7:0] out_byte
    output logic      [1:0]            m_tuser,   // [0] char_valid, [1] run_last
    output logic                       m_tlast,   // text_done
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

    typedef enum logic [1:0] {ST_IDLE, ST_REPL, ST_FLUSH} state_t;

    state_t                      state_reg, state_next;
    logic [CFG_DATA_W-1:0]       pat_bytes_reg, pat_bytes_next;
    logic [LEN_REG_W-1:0]        pat_len_reg, pat_len_next;
    logic [CFG_DATA_W-1:0]       rep_bytes_reg, rep_bytes_next;
    logic [LEN_REG_W-1:0]        rep_len_reg, rep_len_next;
    logic [FILL_W-1:0]           fill_reg, fill_next;
    logic [FILL_W-1:0]           left_reg, left_next;
    logic [RIDX_W-1:0]           ridx_reg, ridx_next;
    logic                        fin_reg, fin_next;
    logic                        m_valid_reg, m_valid_next;
    logic [BYTE_W-1:0]           m_data_reg, m_data_next;
    logic [1:0]                  m_user_reg, m_user_next;
    logic                        m_last_reg, m_last_next;

    logic [FILL_W-1:0]           plen;
    logic [RLEN_W-1:0]           rlen;
    logic [IDX_W-1:0]            wpos;
    logic [FILL_W-1:0]           fill_inc;
    logic                        full;
    logic                        match;
    logic                        out_free;
    logic                        accept;
    logic                        wr_en;
    fsr_cell_ctl_t               ctl;
    logic [MAX_PATTERN-1:0]      cell_wr;
    logic [MAX_PATTERN-1:0]      cell_eq;
    logic [MAX_PATTERN-1:0]      cell_mask;
    logic [BYTE_W-1:0]           cell_eff [MAX_PATTERN];

    logic                        em;
    logic [BYTE_W-1:0]           em_byte;
    logic                        em_cv;
    logic                        em_rl;
    logic                        em_done;

    assign plen = ({28'd0, pat_len_reg} > MAX_PATTERN) ? FILL_W'(MAX_PATTERN)
                                                        : FILL_W'(pat_len_reg);
    assign rlen = ({28'd0, rep_len_reg} > MAX_REPLACEMENT) ? RLEN_W'(MAX_REPLACEMENT)
                                                            : RLEN_W'(rep_len_reg);

    assign wpos     = (fill_reg >= plen) ? '0 : fill_reg[IDX_W-1:0];
    assign fill_inc = FILL_W'(wpos) + FILL_W'(1);
    assign full     = (fill_inc == plen);

    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) && out_free;
    assign accept   = s_tvalid && s_tready;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;
    assign m_tlast  = m_last_reg;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_PATTERN; gi++) begin : g_cell
            logic [BYTE_W-1:0] nbr;
            if (gi == MAX_PATTERN - 1) begin : g_end
                assign nbr = '0;
            end else begin : g_mid
                assign nbr = cell_eff[gi+1];
            end
            assign cell_wr[gi]   = wr_en && (wpos == IDX_W'(gi));
            assign cell_mask[gi] = (FILL_W'(gi) < plen);

            fsr_cell u_cell (
                .aclk     (aclk),
                .ctl      (ctl),
                .wr       (cell_wr[gi]),
                .pat_byte (pat_bytes_reg[gi*BYTE_W +: BYTE_W]),
                .nbr_byte (nbr),
                .eff_byte (cell_eff[gi]),
                .eq       (cell_eq[gi])
            );
        end
    endgenerate

    assign match = &(cell_eq | ~cell_mask);

    always_comb begin
        state_next = state_reg;
        fill_next  = fill_reg;
        left_next  = left_reg;
        ridx_next  = ridx_reg;
        fin_next   = fin_reg;
        em         = 1'b0;
        em_byte    = '0;
        em_cv      = 1'b1;
        em_rl      = 1'b0;
        em_done    = 1'b0;
        wr_en      = 1'b0;
        ctl.shift  = 1'b0;
        ctl.din    = s_tdata;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (plen == '0) begin
                        em        = 1'b1;
                        em_byte   = s_tdata;
                        em_rl     = 1'b1;
                        em_done   = s_tlast;
                        fill_next = '0;
                    end else begin
                        wr_en = 1'b1;
                        if (!full) begin
                            fill_next = fill_inc;
                            if (s_tlast) begin
                                state_next = ST_FLUSH;
                                left_next  = fill_inc;
                            end
                        end else if (match) begin
                            fill_next = '0;
                            if (rlen != '0) begin
                                state_next = ST_REPL;
                                ridx_next  = '0;
                                fin_next   = s_tlast;
                            end else if (s_tlast) begin
                                // empty end marker
                                em      = 1'b1;
                                em_cv   = 1'b0;
                                em_rl   = 1'b1;
                                em_done = 1'b1;
                            end
                        end else begin
                            em        = 1'b1;
                            em_byte   = cell_eff[0];
                            ctl.shift = 1'b1;
                            fill_next = plen - FILL_W'(1);
                            if (s_tlast && (plen > FILL_W'(1))) begin
                                state_next = ST_FLUSH;
                                left_next  = plen - FILL_W'(1);
                            end else begin
                                em_rl   = 1'b1;
                                em_done = s_tlast;
                                if (s_tlast) begin
                                    fill_next = '0;
                                end
                            end
                        end
                    end
                end
            end
            ST_FLUSH: begin
                if (out_free) begin
                    em        = 1'b1;
                    em_byte   = cell_eff[0];
                    ctl.shift = 1'b1;
                    left_next = left_reg - FILL_W'(1);
                    if (left_reg == FILL_W'(1)) begin
                        em_rl      = 1'b1;
                        em_done    = 1'b1;
                        fill_next  = '0;
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_REPL: begin
                if (out_free) begin
                    em        = 1'b1;
                    em_byte   = rep_bytes_reg[ridx_reg*BYTE_W +: BYTE_W];
                    ridx_next = ridx_reg + RIDX_W'(1);
                    if ((RLEN_W'(ridx_reg) + RLEN_W'(1)) == rlen) begin
                        em_rl      = 1'b1;
                        em_done    = fin_reg;
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (cfg_wr_en && (cfg_addr == REG_PATTERN_LENGTH)) begin
            fill_next = '0;
        end
    end

    always_comb begin
        pat_bytes_next = pat_bytes_reg;
        pat_len_next   = pat_len_reg;
        rep_bytes_next = rep_bytes_reg;
        rep_len_next   = rep_len_reg;
        if (cfg_wr_en) begin
            case (cfg_addr)
                REG_PATTERN_BYTES:      pat_bytes_next = cfg_wdata;
                REG_PATTERN_LENGTH:     pat_len_next   = cfg_wdata[LEN_REG_W-1:0];
                REG_REPLACEMENT_BYTES:  rep_bytes_next = cfg_wdata;
                REG_REPLACEMENT_LENGTH: rep_len_next   = cfg_wdata[LEN_REG_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        m_user_next  = m_user_reg;
        m_last_next  = m_last_reg;
        if (em) begin
            m_valid_next = 1'b1;
            m_data_next  = em_byte;
            m_user_next  = {em_rl, em_cv};
            m_last_next  = em_done;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            pat_bytes_reg <= '0;
            pat_len_reg   <= LEN_REG_W'(1);
            rep_bytes_reg <= '0;
            rep_len_reg   <= '0;
            fill_reg      <= '0;
            left_reg      <= '0;
            ridx_reg      <= '0;
            fin_reg       <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            pat_bytes_reg <= pat_bytes_next;
            pat_len_reg   <= pat_len_next;
            rep_bytes_reg <= rep_bytes_next;
            rep_len_reg   <= rep_len_next;
            fill_reg      <= fill_next;
            left_reg      <= left_next;
            ridx_reg      <= ridx_next;
            fin_reg       <= fin_next;
            m_valid_reg   <= m_valid_next;
        end
        m_data_reg <= m_data_next;
        m_user_reg <= m_user_next;
        m_last_reg <= m_last_next;
    end

endmodule

`default_nettype wire

FILE: rtl/fsr_checker.sv
// Port-level checks for the stream find-and-replace block, bound to the top level.
`default_nettype none

module fsr_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       s_tready,
    input wire logic       m_tvalid,
    input wire logic       m_tready,
    input wire logic [7:0] m_tdata,
    input wire logic [1:0] m_tuser,
    input wire logic       m_tlast
);

    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result pending right after reset");

    a_ready_needs_room: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> (!m_tvalid || m_tready))
        else $error("input taken while output register is blocked");

    a_done_is_run_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |-> m_tuser[1])
        else $error("text end without end of run");

    a_marker_form: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[0]) |-> (m_tlast && m_tuser[1] && (m_tdata == 8'd0)))
        else $error("malformed end marker");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("result changed under stall");

endmodule

bind stream_find_replace fsr_checker u_fsr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire

FILE: tb/tb_stream_find_replace.sv
// Self-checking testbench for stream_find_replace: random texts, stalls and register settings.
module tb_stream_find_replace;
    import fsr_pkg::*;

    localparam int RESET_CYCLES   = 12;
    localparam int SETTLE_CYCLES  = 16;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_PHASES  = 8;
    localparam int PHASE_ITEMS    = 25;

    typedef struct packed {
        logic [BYTE_W-1:0] text_byte;
        logic              final_byte;
    } text_item_t;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              char_valid;
        logic              run_last;
        logic              text_done;
    } rewrite_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata   = '0;
    logic                  s_tlast   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [7:0]            m_tdata;
    logic [1:0]            m_tuser;
    logic                  m_tlast;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    stream_find_replace dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Register mirror and search window
    logic [CFG_DATA_W-1:0] pat_word = '0;
    logic [LEN_REG_W-1:0]  pat_len  = 4'd1;
    logic [CFG_DATA_W-1:0] rep_word = '0;
    logic [LEN_REG_W-1:0]  rep_len  = '0;
    logic [BYTE_W-1:0]     win_byte [MAX_PATTERN];
    int                    win_fill = 0;

    text_item_t text_q[$];
    rewrite_t   rewritten_q[$];

    int  n_errors   = 0;
    int  n_in       = 0;
    int  n_out      = 0;
    int  n_texts    = 0;
    int  n_settings = 0;
    int  src_gap    = 0;
    int  sink_stall = 0;
    int  idle_count = 0;
    bit  src_calm   = 1'b0;
    bit  sink_calm  = 1'b0;

    initial begin
        for (int i = 0; i < MAX_PATTERN; i++) win_byte[i] = '0;
    end

    function automatic int pick_gap(input bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 24);
    endfunction

    // Rewrite one text byte and queue the results it produces.
    function automatic void rewrite_byte(input logic [BYTE_W-1:0] b, input logic fin);
        rewrite_t burst[$];
        rewrite_t tail;
        int       plen;
        int       rlen;
        int       i;
        logic     hit;
        plen = (pat_len > MAX_PATTERN) ? MAX_PATTERN : int'(pat_len);
        rlen = (rep_len > MAX_REPLACEMENT) ? MAX_REPLACEMENT : int'(rep_len);
        if (plen == 0) begin
            win_fill = 0;
            burst.push_back({b, 1'b1, 1'b0, 1'b0});
        end else begin
            if (win_fill >= plen) win_fill = 0;
            win_byte[win_fill] = b;
            win_fill++;
            if (win_fill == plen) begin
                hit = 1'b1;
                for (i = 0; i < plen; i++)
                    if (win_byte[i] != pat_word[8*i +: 8]) hit = 1'b0;
                if (hit) begin
                    for (i = 0; i < rlen; i++)
                        burst.push_back({rep_word[8*i +: 8], 1'b1, 1'b0, 1'b0});
                    win_fill = 0;
                end else begin
                    burst.push_back({win_byte[0], 1'b1, 1'b0, 1'b0});
                    for (i = 1; i < plen; i++) win_byte[i-1] = win_byte[i];
                    win_fill--;
                end
            end
        end
        if (fin) begin
            for (i = 0; i < win_fill; i++)
                burst.push_back({win_byte[i], 1'b1, 1'b0, 1'b0});
            win_fill = 0;
            if (burst.size() == 0) burst.push_back({8'h00, 1'b0, 1'b0, 1'b0});
        end
        if (burst.size() > 0) begin
            tail = burst.pop_back();
            tail.run_last  = 1'b1;
            tail.text_done = fin;
            burst.push_back(tail);
        end
        foreach (burst[k]) rewritten_q.push_back(burst[k]);
    endfunction

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            n_errors++;
        end
    endfunction

    // Text byte driver
    always @(posedge aclk) begin
        text_item_t nxt;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                rewrite_byte(s_tdata, s_tlast);
                n_in++;
            end
            if (!s_tvalid || s_tready) begin
                if (src_gap > 0) begin
                    src_gap--;
                    s_tvalid <= 1'b0;
                end else if (text_q.size() > 0) begin
                    nxt = text_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= nxt.text_byte;
                    s_tlast  <= nxt.final_byte;
                    if ($urandom_range(0, 29) == 0) src_calm = !src_calm;
                    src_gap = pick_gap(src_calm);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result monitor and checker
    always @(posedge aclk) begin
        rewrite_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                n_out++;
                if (m_tlast) n_texts++;
                if (rewritten_q.size() == 0) begin
                    $error("unexpected result: out_byte 0x%0h", m_tdata);
                    n_errors++;
                end else begin
                    want = rewritten_q.pop_front();
                    check_field("out_byte", want.out_byte, m_tdata);
                    check_field("char_valid", want.char_valid, m_tuser[0]);
                    check_field("run_last", want.run_last, m_tuser[1]);
                    check_field("text_done", want.text_done, m_tlast);
                end
            end
            if (sink_stall > 0) begin
                sink_stall--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if (m_tvalid && m_tready) begin
                    if ($urandom_range(0, 29) == 0) sink_calm = !sink_calm;
                    sink_stall = pick_gap(sink_calm);
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_count = 0;
        else idle_count++;
        if (idle_count >= WATCHDOG_LIMIT) begin
            $display("tb_stream_find_replace: FAIL");
            $finish;
        end
    end

    task automatic push_item(input logic [BYTE_W-1:0] b, input logic fin);
        text_q.push_back({b, fin});
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        case (idx)
            REG_PATTERN_BYTES:      pat_word = val;
            REG_PATTERN_LENGTH: begin
                pat_len  = val[LEN_REG_W-1:0];
                win_fill = 0;
            end
            REG_REPLACEMENT_BYTES:  rep_word = val;
            REG_REPLACEMENT_LENGTH: rep_len = val[LEN_REG_W-1:0];
            default: ;
        endcase
    endtask

    task automatic configure(input logic [63:0] pw, input int pl,
                             input logic [63:0] rw, input int rl);
        write_reg(REG_PATTERN_BYTES, pw);
        write_reg(REG_PATTERN_LENGTH, 64'(pl));
        write_reg(REG_REPLACEMENT_BYTES, rw);
        write_reg(REG_REPLACEMENT_LENGTH, 64'(rl));
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        n_settings++;
    endtask

    // Wait until every queued item is in and every expected result is out.
    task automatic drain();
        while (text_q.size() > 0 || s_tvalid || rewritten_q.size() > 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Texts built mostly from copies and prefixes of the search word.
    task automatic queue_texts(input int n_items);
        logic [BYTE_W-1:0] body[$];
        int                plen;
        int                pick;
        int                cut;
        int                i;
        logic              fin;
        plen = (pat_len > MAX_PATTERN) ? MAX_PATTERN : int'(pat_len);
        if (plen == 0) plen = $urandom_range(1, 4);
        while (body.size() < n_items) begin
            pick = $urandom_range(0, 99);
            if (pick < 35) begin
                for (i = 0; i < plen; i++) body.push_back(pat_word[8*i +: 8]);
            end else if (pick < 55) begin
                cut = $urandom_range(1, plen);
                for (i = 0; i < cut; i++) body.push_back(pat_word[8*i +: 8]);
            end else if (pick < 75) begin
                body.push_back(pat_word[8*$urandom_range(0, plen - 1) +: 8]);
            end else begin
                body.push_back(8'($urandom_range(0, 255)));
            end
        end
        for (i = 0; i < n_items; i++) begin
            fin = ($urandom_range(0, 7) == 0);
            if (i == n_items - 1) fin = ($urandom_range(0, 3) != 0);
            push_item(body[i], fin);
        end
    endtask

    initial begin
        logic [63:0] pw;
        int          pl;
        int          rl;
        int          ph;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset setting: search word is one zero byte, empty replacement
        push_item(8'h00, 1'b0);
        push_item(8'hFF, 1'b1);
        push_item(8'h00, 1'b1);
        drain();

        // "ab" -> "XYZ"; ends mid-text so the next length write drops a held byte
        configure(64'h6261, 2, 64'h5A5958, 3);
        push_item(8'h61, 1'b0);
        push_item(8'h62, 1'b0);
        push_item(8'h61, 1'b0);
        push_item(8'h61, 1'b0);
        push_item(8'h62, 1'b0);
        push_item(8'h63, 1'b1);
        push_item(8'h61, 1'b1);
        push_item(8'h61, 1'b0);
        drain();

        // Oversized lengths saturate to eight
        configure({8{8'hFF}}, 15, 64'h0, 15);
        repeat (7) push_item(8'hFF, 1'b0);
        push_item(8'hFF, 1'b1);
        drain();

        // Zero search length passes bytes through
        configure({$urandom, $urandom}, 0, {$urandom, $urandom}, 2);
        push_item(8'h5A, 1'b0);
        push_item(8'hA5, 1'b1);
        drain();

        for (ph = 0; ph < RANDOM_PHASES; ph++) begin
            case (ph)
                0: begin pl = 1; rl = 8; end
                1: begin pl = 8; rl = 0; end
                2: begin pl = 8; rl = 8; end
                default: begin
                    pl = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15)
                                                     : $urandom_range(1, 5);
                    rl = $urandom_range(0, 6);
                end
            endcase
            pw = (ph % 3 == 0) ? {8{8'($urandom_range(0, 255))}} : {$urandom, $urandom};
            configure(pw, pl, {$urandom, $urandom}, rl);
            queue_texts(PHASE_ITEMS);
            drain();
        end

        $display("Rewrote %0d text items into %0d checked results (%0d complete texts)",
                 n_in, n_out, n_texts);
        $display("across %0d register settings, with random gaps and output stalls.",
                 n_settings);
        if (n_errors == 0) begin
            $display("tb_stream_find_replace: PASS");
        end else begin
            $display("tb_stream_find_replace: FAIL");
        end
        $finish;
    end

endmodule
